### rtl/core/sacm_pkg.sv
`default_nettype none
package sacm_pkg;

    localparam int unsigned TAG_W         = 30;
    localparam int unsigned TIME_W        = 32;
    localparam int unsigned CNT_W         = 32;
    localparam int unsigned COST_W        = 14;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 4;
    localparam int unsigned MEM_WORD_COST = 100;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LRU_POLICY     = 3'd5;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_STORE = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] address;
    } in_t;

    typedef struct packed {
        logic              hit;
        logic              filled;
        logic              evicted;
        logic              dirty_evict;
        logic [COST_W-1:0] cycles_added;
        logic [CNT_W-1:0]  cycle_total;
        logic [CNT_W-1:0]  load_count;
        logic [CNT_W-1:0]  store_count;
        logic [CNT_W-1:0]  load_hit_count;
        logic [CNT_W-1:0]  load_miss_count;
        logic [CNT_W-1:0]  store_hit_count;
        logic [CNT_W-1:0]  store_miss_count;
    } out_t;

    // One way of one set
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic              dirty;
        logic [TIME_W-1:0] access_time;
        logic [TIME_W-1:0] load_time;
    } entry_t;

    // Control from the sequencer to the scan unit
    typedef struct packed {
        logic clear;
        logic step;
        logic lru;
    } scan_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_LOAD_N,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_STAMP,
        ST_COMMIT,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

### rtl/core/set_assoc_cache_tag_model.sv
`default_nettype none
// Cache tag model: tracks tags, dirty marks and timestamps of a
// set-associative cache and reports hit/miss, fill, eviction and cycle cost.
//
// Input channel (in_valid / in_stall / in_data) takes one access beat:
// load or store with a 32-bit byte address. Output channel (out_valid /
// out_stall / out_data) returns one result beat per access with the
// running counters. The config port (cfg_we / cfg_index / cfg_data) writes
// the policy registers; write it only while the block is idle.
//
// One access at a time. The result beat follows a scan over the N blocks
// held in the addressed set (0..NUM_WAYS): the shared compare unit reads
// one way at a time from the way RAM. in_stall stays high from accept until
// the result beat is taken, so the next access is accepted only after the
// previous result beat has been taken.
//
// Reset empties every set and clears the counters and cycle total; the
// config registers return to offset 4, index 8, 4 ways, write-allocate,
// write-back, LRU. While out_stall is high the result beat holds steady.
module set_assoc_cache_tag_model #(
    parameter int unsigned NUM_SETS        = 256,
    parameter int unsigned NUM_WAYS        = 4,
    parameter int unsigned MAX_OFFSET_BITS = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire sacm_pkg::in_t                      in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output sacm_pkg::out_t                          out_data,
    input  wire logic                               cfg_we,
    input  wire logic [sacm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sacm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sacm_pkg::*;

    localparam int unsigned SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int unsigned WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int unsigned FILL_W  = $clog2(NUM_WAYS + 1);
    localparam int unsigned DEPTH   = NUM_SETS * NUM_WAYS;
    localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned MAX_IB  = $clog2(NUM_SETS + 1) - 1;
    localparam int unsigned BLK_W   = 7 + MAX_OFFSET_BITS - 2;
    localparam int unsigned PRE_W   = BLK_W + 2;
    localparam int unsigned POST_W  = 7;
    localparam int unsigned SUM_W   = PRE_W + 1;

    // Config registers
    logic [3:0] offset_bits_reg;
    logic [3:0] index_bits_reg;
    logic [2:0] ways_in_use_reg;
    logic       write_allocate_reg;
    logic       write_back_reg;
    logic       lru_policy_reg;

    // Access context
    logic              store_reg;
    logic [SET_W-1:0]  set_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [FILL_W-1:0] n_reg;
    logic [FILL_W-1:0] i_reg;
    logic [TIME_W-1:0] stamp_reg;

    // Totals
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] loads_reg;
    logic [CNT_W-1:0] stores_reg;
    logic [CNT_W-1:0] load_hits_reg;
    logic [CNT_W-1:0] load_misses_reg;
    logic [CNT_W-1:0] store_hits_reg;
    logic [CNT_W-1:0] store_misses_reg;

    state_t state_reg;
    state_t state_next;
    out_t   out_reg;

    // Address split at accept
    logic [3:0]        ob_eff;
    logic [3:0]        ib_eff;
    logic [31:0]       set_full;
    logic [SET_W-1:0]  set_calc;
    logic [TAG_W-1:0]  tag_calc;
    logic [BLK_W-1:0]  blk_calc;
    logic              in_accept;
    logic              out_accept;

    always_comb
    begin
        ob_eff = offset_bits_reg;
        if (offset_bits_reg < 4'd2)
        begin
            ob_eff = 4'd2;
        end
        else if (32'(offset_bits_reg) > MAX_OFFSET_BITS)
        begin
            ob_eff = 4'(MAX_OFFSET_BITS);
        end
        ib_eff = index_bits_reg;
        if (32'(index_bits_reg) > MAX_IB)
        begin
            ib_eff = 4'(MAX_IB);
        end
    end

    assign set_full  = (in_data.address >> ob_eff) & ((32'd1 << ib_eff) - 32'd1);
    assign set_calc  = SET_W'(set_full);
    assign tag_calc  = TAG_W'(in_data.address >> (5'(ob_eff) + 5'(ib_eff)));
    assign blk_calc  = BLK_W'(MEM_WORD_COST) << (ob_eff - 4'd2);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;

    // Submodule wiring
    scan_ctl_t        scan_ctl;
    logic             fill_rd_en;
    logic [FILL_W-1:0] fill_level;
    logic             fill_wr_en;
    logic             way_rd_en;
    logic             way_wr_en;
    logic [ADDR_W-1:0] way_rd_addr;
    logic [ADDR_W-1:0] way_wr_addr;
    entry_t           way_rd_data;
    entry_t           way_wr_data;
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    entry_t           hit_entry;
    logic [WAY_W-1:0] vict_way;
    logic             vict_dirty;

    sacm_fill_store #(
        .NUM_SETS (NUM_SETS),
        .SET_W    (SET_W),
        .FILL_W   (FILL_W)
    ) u_fill (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (fill_rd_en),
        .rd_addr  (set_reg),
        .rd_level (fill_level),
        .wr_en    (fill_wr_en),
        .wr_addr  (set_reg),
        .wr_level (n_reg + FILL_W'(1))
    );

    sacm_way_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (way_rd_en),
        .rd_addr (way_rd_addr),
        .rd_data (way_rd_data),
        .wr_en   (way_wr_en),
        .wr_addr (way_wr_addr),
        .wr_data (way_wr_data)
    );

    sacm_scan #(
        .WAY_W (WAY_W)
    ) u_scan (
        .clk        (clk),
        .ctl        (scan_ctl),
        .idx        (i_reg[WAY_W-1:0]),
        .entry      (way_rd_data),
        .tag        (tag_reg),
        .hit        (hit),
        .hit_way    (hit_way),
        .hit_entry  (hit_entry),
        .vict_way   (vict_way),
        .vict_dirty (vict_dirty)
    );

    // Decide the access outcome from the scan results
    logic [FILL_W-1:0] ways_eff;
    logic              do_place;
    logic              replace;
    logic              dev;
    logic              wt_store;
    logic [PRE_W-1:0]  pre;
    logic [POST_W-1:0] post;
    logic [WAY_W-1:0]  slot;
    logic [WAY_W-1:0]  wr_way;

    always_comb
    begin
        ways_eff = FILL_W'(ways_in_use_reg);
        if (ways_in_use_reg == 3'd0)
        begin
            ways_eff = FILL_W'(1);
        end
        else if (32'(ways_in_use_reg) > NUM_WAYS)
        begin
            ways_eff = FILL_W'(NUM_WAYS);
        end
        do_place = !hit && (!store_reg || write_allocate_reg);
        replace  = (n_reg >= ways_eff);
        dev      = do_place && replace && write_back_reg && vict_dirty;
        wt_store = store_reg && !write_back_reg;
        slot     = replace ? vict_way : WAY_W'(n_reg);
        wr_way   = hit ? hit_way : slot;
        if (hit)
        begin
            pre  = '0;
            post = wt_store ? POST_W'(MEM_WORD_COST + 1) : POST_W'(1);
        end
        else if (!do_place)
        begin
            pre  = PRE_W'(MEM_WORD_COST);
            post = '0;
        end
        else
        begin
            pre  = PRE_W'(blk_reg) + (wt_store ? PRE_W'(MEM_WORD_COST) : '0)
                 + (dev ? PRE_W'(blk_reg) : '0);
            post = POST_W'(1);
        end
    end

    // Memory ports
    always_comb
    begin
        way_rd_addr = ADDR_W'(set_reg) * ADDR_W'(NUM_WAYS) + ADDR_W'(i_reg[WAY_W-1:0]);
        way_wr_addr = ADDR_W'(set_reg) * ADDR_W'(NUM_WAYS) + ADDR_W'(wr_way);
        if (hit)
        begin
            way_wr_data             = hit_entry;
            way_wr_data.access_time = stamp_reg;
            way_wr_data.dirty       = hit_entry.dirty | (store_reg & write_back_reg);
        end
        else
        begin
            way_wr_data.tag         = tag_reg;
            way_wr_data.dirty       = store_reg & write_back_reg;
            way_wr_data.access_time = stamp_reg;
            way_wr_data.load_time   = stamp_reg;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:     state_next = ST_LOAD_N;
            ST_LOAD_N:   state_next = ST_SCAN_RD;
            ST_SCAN_RD:  state_next = (i_reg < n_reg) ? ST_SCAN_CMP : ST_STAMP;
            ST_SCAN_CMP: state_next = ST_SCAN_RD;
            ST_STAMP:    state_next = ST_COMMIT;
            ST_COMMIT:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_accept)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_stall       = (state_reg != ST_IDLE);
        out_valid      = (state_reg == ST_OUT);
        fill_rd_en     = (state_reg == ST_FILL);
        way_rd_en      = (state_reg == ST_SCAN_RD) && (i_reg < n_reg);
        scan_ctl.clear = (state_reg == ST_LOAD_N);
        scan_ctl.step  = (state_reg == ST_SCAN_CMP);
        scan_ctl.lru   = lru_policy_reg;
        way_wr_en      = (state_reg == ST_COMMIT) && (hit || do_place);
        fill_wr_en     = (state_reg == ST_COMMIT) && do_place && !replace;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg    <= 4'd4;
            index_bits_reg     <= 4'd8;
            ways_in_use_reg    <= 3'd4;
            write_allocate_reg <= 1'b1;
            write_back_reg     <= 1'b1;
            lru_policy_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OFFSET_BITS:    offset_bits_reg    <= cfg_data;
                CFG_INDEX_BITS:     index_bits_reg     <= cfg_data;
                CFG_WAYS_IN_USE:    ways_in_use_reg    <= cfg_data[2:0];
                CFG_WRITE_ALLOCATE: write_allocate_reg <= cfg_data[0];
                CFG_WRITE_BACK:     write_back_reg     <= cfg_data[0];
                CFG_LRU_POLICY:     lru_policy_reg     <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Access context and scan counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            n_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_LOAD_N)
            begin
                n_reg <= fill_level;
                i_reg <= '0;
            end
            else if (state_reg == ST_SCAN_CMP)
            begin
                i_reg <= i_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            store_reg <= in_data.mode;
            set_reg   <= set_calc;
            tag_reg   <= tag_calc;
            blk_reg   <= blk_calc;
        end
        if (state_reg == ST_STAMP)
        begin
            stamp_reg <= total_reg + TIME_W'(pre);
        end
    end

    // Advance counters and load the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg        <= '0;
            loads_reg        <= '0;
            stores_reg       <= '0;
            load_hits_reg    <= '0;
            load_misses_reg  <= '0;
            store_hits_reg   <= '0;
            store_misses_reg <= '0;
        end
        else if (state_reg == ST_COMMIT)
        begin
            total_reg <= stamp_reg + CNT_W'(post);
            if (store_reg == MODE_STORE)
            begin
                stores_reg <= stores_reg + CNT_W'(1);
                if (hit)
                begin
                    store_hits_reg <= store_hits_reg + CNT_W'(1);
                end
                else
                begin
                    store_misses_reg <= store_misses_reg + CNT_W'(1);
                end
            end
            else
            begin
                loads_reg <= loads_reg + CNT_W'(1);
                if (hit)
                begin
                    load_hits_reg <= load_hits_reg + CNT_W'(1);
                end
                else
                begin
                    load_misses_reg <= load_misses_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_COMMIT)
        begin
            out_reg.hit          <= hit;
            out_reg.filled       <= do_place;
            out_reg.evicted      <= do_place && replace;
            out_reg.dirty_evict  <= dev;
            out_reg.cycles_added <= COST_W'(SUM_W'(pre) + SUM_W'(post));
            out_reg.cycle_total  <= stamp_reg + CNT_W'(post);
            out_reg.load_count   <= loads_reg + CNT_W'(store_reg == MODE_LOAD);
            out_reg.store_count  <= stores_reg + CNT_W'(store_reg == MODE_STORE);
            out_reg.load_hit_count <= load_hits_reg
                                    + CNT_W'((store_reg == MODE_LOAD) && hit);
            out_reg.load_miss_count <= load_misses_reg
                                     + CNT_W'((store_reg == MODE_LOAD) && !hit);
            out_reg.store_hit_count <= store_hits_reg
                                     + CNT_W'((store_reg == MODE_STORE) && hit);
            out_reg.store_miss_count <= store_misses_reg
                                      + CNT_W'((store_reg == MODE_STORE) && !hit);
        end
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire

### rtl/core/sacm_fill_store.sv
`default_nettype none
module sacm_fill_store #(
    parameter int unsigned NUM_SETS = 256,
    parameter int unsigned SET_W    = 8,
    parameter int unsigned FILL_W   = 3
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [SET_W-1:0]  rd_addr,
    output logic      [FILL_W-1:0] rd_level,
    input  wire logic              wr_en,
    input  wire logic [SET_W-1:0]  wr_addr,
    input  wire logic [FILL_W-1:0] wr_level
);

    logic [FILL_W-1:0]   mem [NUM_SETS];
    logic [NUM_SETS-1:0] valid_reg;
    logic [FILL_W-1:0]   data_reg;
    logic                hit_valid_reg;

    // Hold the per-set valid marks; reset empties every set at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            hit_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_level;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    // A set never written reads as empty
    assign rd_level = hit_valid_reg ? data_reg : '0;

endmodule
`default_nettype wire

### rtl/core/sacm_way_ram.sv
`default_nettype none
module sacm_way_ram #(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rd_en,
    input  wire logic [ADDR_W-1:0]     rd_addr,
    output sacm_pkg::entry_t           rd_data,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_W-1:0]     wr_addr,
    input  wire sacm_pkg::entry_t      wr_data
);
    import sacm_pkg::*;

    entry_t mem [DEPTH];
    entry_t data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = data_reg;

endmodule
`default_nettype wire

### rtl/core/sacm_scan.sv
`default_nettype none
module sacm_scan #(
    parameter int unsigned WAY_W = 2
) (
    input  wire logic                   clk,
    input  wire sacm_pkg::scan_ctl_t    ctl,
    input  wire logic [WAY_W-1:0]       idx,
    input  wire sacm_pkg::entry_t       entry,
    input  wire logic [sacm_pkg::TAG_W-1:0] tag,
    output logic                        hit,
    output logic      [WAY_W-1:0]       hit_way,
    output sacm_pkg::entry_t            hit_entry,
    output logic      [WAY_W-1:0]       vict_way,
    output logic                        vict_dirty
);
    import sacm_pkg::*;

    logic              hit_reg;
    logic [WAY_W-1:0]  hit_way_reg;
    entry_t            hit_entry_reg;
    logic [WAY_W-1:0]  vict_way_reg;
    logic              vict_dirty_reg;
    logic [TIME_W-1:0] vict_time_reg;
    logic [TIME_W-1:0] stamp;
    logic              match;
    logic              older;

    // Shared compare: tag match and timestamp order, one way per step
    assign stamp = ctl.lru ? entry.access_time : entry.load_time;
    assign match = (entry.tag == tag);
    assign older = (idx == '0) || (stamp < vict_time_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            // Keep the lowest matching way
            if (!hit_reg && match)
            begin
                hit_reg       <= 1'b1;
                hit_way_reg   <= idx;
                hit_entry_reg <= entry;
            end
            // Strict compare leaves ties with the lower way
            if (older)
            begin
                vict_way_reg   <= idx;
                vict_dirty_reg <= entry.dirty;
                vict_time_reg  <= stamp;
            end
        end
    end

    assign hit        = hit_reg;
    assign hit_way    = hit_way_reg;
    assign hit_entry  = hit_entry_reg;
    assign vict_way   = vict_way_reg;
    assign vict_dirty = vict_dirty_reg;

endmodule
`default_nettype wire

### rtl/core/sacm_checker.sv
`default_nettype none
module sacm_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           in_valid,
    input wire logic           in_stall,
    input wire logic           out_valid,
    input wire logic           out_stall,
    input wire sacm_pkg::out_t out_data
);

    // One access in flight: accept blocks the input until the result is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && !out_valid))
        else $error("input not blocked after accept");

    // A waiting result keeps the input closed
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result pending");

    // A taken result beat is not repeated
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
        else $error("result beat repeated");

    // Stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

endmodule

bind set_assoc_cache_tag_model sacm_checker u_sacm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import sacm_pkg::*;

    localparam int N_SETS = 256;
    localparam int N_WAYS = 4;
    localparam int MAX_OB = 8;
    localparam int MAX_IB = 8;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;
    localparam int EXP_DEPTH = 64;
    localparam int N_DIR = 13;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    set_assoc_cache_tag_model uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // Shadow copy of the cache tags and policy
    logic [3:0] sh_offset, sh_index;
    logic [2:0] sh_ways;
    logic sh_walloc, sh_wback, sh_lru;
    int unsigned sh_fill [N_SETS];
    logic [29:0] sh_tag [N_SETS][N_WAYS];
    logic sh_dirty [N_SETS][N_WAYS];
    logic [31:0] sh_atime [N_SETS][N_WAYS];
    logic [31:0] sh_ltime [N_SETS][N_WAYS];
    logic [31:0] sh_cycles, sh_loads, sh_stores, sh_lhit, sh_lmiss, sh_shit, sh_smiss;

    // Expected result beats in order, with the hand-typed fields of directed rows
    out_t exp_beat [EXP_DEPTH];
    bit exp_typed [EXP_DEPTH];
    logic exp_hit [EXP_DEPTH];
    logic [13:0] exp_cost [EXP_DEPTH];
    int exp_wr = 0;
    int exp_rd = 0;

    int errors = 0;
    int mismatches = 0;
    int accepted_in = 0;
    int accepted_out = 0;
    int idle_cycles = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit long_hold = 1'b0;

    function automatic void cache_reset();
        sh_offset = 4; sh_index = 8; sh_ways = 4;
        sh_walloc = 1; sh_wback = 1; sh_lru = 1;
        for (int s = 0; s < N_SETS; s++)
        begin
            sh_fill[s] = 0;
        end
        sh_cycles = 0; sh_loads = 0; sh_stores = 0;
        sh_lhit = 0; sh_lmiss = 0; sh_shit = 0; sh_smiss = 0;
    endfunction

    // Put a block into a set, evicting the oldest way when full
    function automatic void cache_place(int unsigned s, logic [29:0] tg, logic drt,
                                        logic [31:0] blk, ref out_t r);
        int unsigned n, w, slot;
        logic [31:0] a, b;
        n = sh_fill[s] > N_WAYS ? N_WAYS : sh_fill[s];
        w = sh_ways == 0 ? 1 : (sh_ways > N_WAYS ? N_WAYS : sh_ways);
        if (n >= w && n > 0)
        begin
            slot = 0;
            for (int i = 1; i < n; i++)
            begin
                a = sh_lru ? sh_atime[s][i] : sh_ltime[s][i];
                b = sh_lru ? sh_atime[s][slot] : sh_ltime[s][slot];
                if (a < b)
                begin
                    slot = i;
                end
            end
            r.evicted = 1'b1;
            if (sh_wback && sh_dirty[s][slot])
            begin
                r.dirty_evict = 1'b1;
                sh_cycles += blk;
            end
        end
        else
        begin
            slot = n;
            sh_fill[s] = n + 1;
        end
        sh_tag[s][slot] = tg;
        sh_dirty[s][slot] = drt;
        sh_atime[s][slot] = sh_cycles;
        sh_ltime[s][slot] = sh_cycles;
        sh_cycles += 1;
    endfunction

    function automatic out_t cache_access(in_t acc);
        out_t r;
        int unsigned ob, ib, s, n, w;
        logic [31:0] blk, tg, start;
        logic hit;
        r = '0;
        ob = sh_offset < 2 ? 2 : (sh_offset > MAX_OB ? MAX_OB : sh_offset);
        ib = sh_index > MAX_IB ? MAX_IB : sh_index;
        blk = 32'd100 << (ob - 2);
        s = (acc.address >> ob) & ((1 << ib) - 1);
        tg = acc.address >> (ob + ib);
        n = sh_fill[s] > N_WAYS ? N_WAYS : sh_fill[s];
        hit = 1'b0;
        w = 0;
        for (int i = 0; i < n; i++)
        begin
            if (!hit && sh_tag[s][i] == tg[29:0])
            begin
                hit = 1'b1;
                w = i;
            end
        end
        start = sh_cycles;
        if (acc.mode == MODE_LOAD)
        begin
            sh_loads++;
            if (hit)
            begin
                sh_lhit++;
                sh_atime[s][w] = sh_cycles;
                sh_cycles += 1;
            end
            else
            begin
                sh_lmiss++;
                sh_cycles += blk;
                r.filled = 1'b1;
                cache_place(s, tg[29:0], 1'b0, blk, r);
            end
        end
        else
        begin
            sh_stores++;
            if (hit)
            begin
                sh_shit++;
                sh_atime[s][w] = sh_cycles;
                if (sh_wback)
                begin
                    sh_dirty[s][w] = 1'b1;
                end
                else
                begin
                    sh_cycles += 100;
                end
                sh_cycles += 1;
            end
            else
            begin
                sh_smiss++;
                if (!sh_walloc)
                begin
                    sh_cycles += 100;
                end
                else
                begin
                    sh_cycles += blk;
                    if (!sh_wback)
                    begin
                        sh_cycles += 100;
                    end
                    r.filled = 1'b1;
                    cache_place(s, tg[29:0], sh_wback, blk, r);
                end
            end
        end
        r.hit = hit;
        r.cycles_added = 14'(sh_cycles - start);
        r.cycle_total = sh_cycles;
        r.load_count = sh_loads;
        r.store_count = sh_stores;
        r.load_hit_count = sh_lhit;
        r.load_miss_count = sh_lmiss;
        r.store_hit_count = sh_shit;
        r.store_miss_count = sh_smiss;
        return r;
    endfunction

    // Check result beats against the oldest expectation
    always @(posedge clk)
    begin
        out_t want;
        int slot;
        if (rst_n && out_valid && !out_stall)
        begin
            accepted_out++;
            if (exp_rd == exp_wr)
            begin
                errors++;
                if (mismatches++ < 10)
                begin
                    $display("ERROR: unexpected result %h", out_data);
                end
            end
            else
            begin
                slot = exp_rd % EXP_DEPTH;
                want = exp_beat[slot];
                exp_rd++;
                if (out_data !== want)
                begin
                    errors++;
                    if (mismatches++ < 10)
                    begin
                        $display("ERROR: result mismatch exp %h got %h", want, out_data);
                    end
                end
                if (exp_typed[slot] && (out_data.hit !== exp_hit[slot]
                                        || out_data.cycles_added !== exp_cost[slot]))
                begin
                    errors++;
                    if (mismatches++ < 10)
                    begin
                        $display("ERROR: directed row exp hit %0d cost %0d got hit %0d cost %0d",
                                 exp_hit[slot], exp_cost[slot],
                                 out_data.hit, out_data.cycles_added);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver stall, random or held for a long stretch
    always @(negedge clk)
    begin
        if (long_hold)
        begin
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < snk_idle_pct);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [3:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_OFFSET_BITS:    sh_offset = val;
            CFG_INDEX_BITS:     sh_index = val;
            CFG_WAYS_IN_USE:    sh_ways = val[2:0];
            CFG_WRITE_ALLOCATE: sh_walloc = val[0];
            CFG_WRITE_BACK:     sh_wback = val[0];
            CFG_LRU_POLICY:     sh_lru = val[0];
            default:            ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drive one access beat and queue its expected result
    task automatic send_access(in_t acc, bit typed, logic t_hit, logic [13:0] t_cost);
        int slot;
        @(negedge clk);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        slot = exp_wr % EXP_DEPTH;
        exp_beat[slot] = cache_access(acc);
        exp_typed[slot] = typed;
        exp_hit[slot] = t_hit;
        exp_cost[slot] = t_cost;
        exp_wr++;
        in_data <= acc;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        accepted_in++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (exp_rd != exp_wr && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic in_t rand_access(int unsigned pool);
        in_t a;
        a.mode = 1'($urandom_range(1));
        // Mostly reuse a small address pool so hits and evictions happen
        if ($urandom_range(99) < 80)
        begin
            a.address = (32'($urandom_range(pool)) << 12)
                      ^ (32'($urandom_range(3)) << 20)
                      ^ ($urandom & 32'h0000_0FFF);
        end
        else
        begin
            a.address = $urandom;
        end
        return a;
    endfunction

    typedef struct {
        logic mode;
        logic [31:0] address;
        logic typed;
        logic hit;
        logic [13:0] cost;
    } dir_row_t;

    dir_row_t dir_rows [N_DIR] = '{
        '{MODE_LOAD,  32'h0000_0000, 1'b1, 1'b0, 14'd401},
        '{MODE_LOAD,  32'h0000_0004, 1'b1, 1'b1, 14'd1},
        '{MODE_STORE, 32'h0000_0008, 1'b1, 1'b1, 14'd1},
        '{MODE_STORE, 32'hFFFF_FFFF, 1'b1, 1'b0, 14'd401},
        '{MODE_LOAD,  32'hFFFF_FFF0, 1'b1, 1'b1, 14'd1},
        '{MODE_LOAD,  32'h0001_0000, 1'b0, 1'b0, 14'd0},
        '{MODE_LOAD,  32'h0002_0000, 1'b0, 1'b0, 14'd0},
        '{MODE_LOAD,  32'h0003_0000, 1'b0, 1'b0, 14'd0},
        '{MODE_STORE, 32'h0004_0000, 1'b0, 1'b0, 14'd0},
        '{MODE_LOAD,  32'h0005_0000, 1'b0, 1'b0, 14'd0},
        '{MODE_LOAD,  32'h0000_0000, 1'b0, 1'b0, 14'd0},
        '{MODE_STORE, 32'hAAAA_AAAA, 1'b0, 1'b0, 14'd0},
        '{MODE_LOAD,  32'h5555_5555, 1'b0, 1'b0, 14'd0}
    };

    int phase_items;
    in_t acc;

    initial
    begin
        cache_reset();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed table at reset settings
        for (int i = 0; i < N_DIR; i++)
        begin
            acc.mode = dir_rows[i].mode;
            acc.address = dir_rows[i].address;
            send_access(acc, dir_rows[i].typed, dir_rows[i].hit, dir_rows[i].cost);
        end
        drain();

        // Random phases over several settings, extremes included
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 84;
                    snk_idle_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 84;
                end
                3:
                begin
                    src_idle_pct = 38;
                    snk_idle_pct = 38;
                end
                default:
                begin
                    src_idle_pct = $urandom_range(1) * 20;
                    snk_idle_pct = 20;
                end
            endcase
            write_reg(CFG_OFFSET_BITS,
                      ph == 0 ? 4'd15 : (ph == 1 ? 4'd0 : 4'($urandom_range(8, 2))));
            write_reg(CFG_INDEX_BITS,
                      ph == 2 ? 4'd15 : (ph == 3 ? 4'd0 : 4'($urandom_range(3))));
            write_reg(CFG_WAYS_IN_USE,
                      ph == 4 ? 4'd0 : (ph == 5 ? 4'd7 : 4'($urandom_range(4, 1))));
            write_reg(CFG_WRITE_ALLOCATE, 4'(ph[0]));
            write_reg(CFG_WRITE_BACK, 4'(ph[1]));
            write_reg(CFG_LRU_POLICY, 4'(ph[2]));
            if (ph == 6)
            begin
                // Hold the receiver off while the sender keeps offering
                fork
                    begin
                        long_hold = 1'b1;
                        repeat (300) @(posedge clk);
                        long_hold = 1'b0;
                    end
                    for (int k = 0; k < 6; k++)
                    begin
                        send_access(rand_access(7), 1'b0, 1'b0, 14'd0);
                    end
                join
            end
            phase_items = 80;
            for (int k = 0; k < phase_items; k++)
            begin
                send_access(rand_access(ph < 4 ? 3 : 15), 1'b0, 1'b0, 14'd0);
            end
            // Pause until every expected result has arrived
            drain();
        end

        drain();
        $display("Covered %0d accesses and %0d results over 8 policy settings,",
                 accepted_in, accepted_out);
        $display("with idle, stall and long back-pressure phases.");
        if (errors == 0 && exp_rd == exp_wr)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

### set_assoc_cache_tag_model.f
rtl/core/sacm_pkg.sv
rtl/core/sacm_fill_store.sv
rtl/core/sacm_way_ram.sv
rtl/core/sacm_scan.sv
rtl/core/set_assoc_cache_tag_model.sv
rtl/core/sacm_checker.sv
tb/sv/testbench.sv
